// ----- rtl/tstg_pkg.sv -----
// shared constants, templates and packet byte builder for the transport packet test generator
`default_nettype none
package tstg_pkg;

  localparam int unsigned PKT_WORDS = 47;
  localparam int unsigned TIME_W    = 42;
  localparam int unsigned BASE_W    = 33;
  localparam int unsigned EXT_W     = 9;
  localparam int unsigned PID_W     = 13;
  localparam int unsigned PHASE_W   = 16;
  localparam int unsigned CC_W      = 4;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned PCR_DIV   = 300;

  localparam logic [KIND_W-1:0] KIND_PAT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PMT   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PCR   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_VIDEO = 2'd3;

  localparam logic [2:0] REG_TABLE_PERIOD = 3'd0;
  localparam logic [2:0] REG_PCR_PERIOD   = 3'd1;
  localparam logic [2:0] REG_VIDEO_START  = 3'd2;
  localparam logic [2:0] REG_VID_PID      = 3'd3;
  localparam logic [2:0] REG_PCR_PID      = 3'd4;

  localparam logic [15:0] TABLE_PERIOD_RST = 16'd1000;
  localparam logic [15:0] PCR_PERIOD_RST   = 16'd40;
  localparam logic [15:0] VIDEO_START_RST  = 16'd10;
  localparam logic [12:0] VID_PID_RST      = 13'h0100;
  localparam logic [12:0] PCR_PID_RST      = 13'h0100;

  localparam logic [7:0] SYNC_BYTE = 8'h47;
  localparam logic [7:0] FILL_BYTE = 8'hFF;

  localparam logic [7:0] PAT_TPL [32] = '{
    8'h47, 8'h40, 8'h00, 8'h10, 8'h00, 8'h00, 8'hb0, 8'h0d,
    8'h00, 8'h01, 8'hc1, 8'h00, 8'h00, 8'h00, 8'h01, 8'he1,
    8'h00, 8'h24, 8'hac, 8'h48, 8'hbd, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  localparam logic [7:0] PMT_TPL [32] = '{
    8'h47, 8'h41, 8'h00, 8'h10, 8'h00, 8'h02, 8'hb0, 8'h17,
    8'h00, 8'h01, 8'hc1, 8'h00, 8'h00, 8'he1, 8'h00, 8'hf0,
    8'h00, 8'h1b, 8'he1, 8'h00, 8'hf0, 8'h00, 8'h4e, 8'h59,
    8'h3d, 8'h1e, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // pes header at bytes 4..12, h.264 parameter sets and slice start at 13..57
  localparam logic [7:0] START_TPL [64] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'he0,
    8'h00, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h01, 8'h67, 8'h42, 8'h00, 8'h1f, 8'h95, 8'ha8, 8'h1e,
    8'h00, 8'h5b, 8'h90, 8'h00, 8'h00, 8'h00, 8'h01, 8'h68,
    8'hce, 8'h3c, 8'h80, 8'h00, 8'h00, 8'h00, 8'h01, 8'h06,
    8'h04, 8'h08, 8'h47, 8'h41, 8'h39, 8'h34, 8'h03, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h65, 8'h00, 8'h00,
    8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CC_W-1:0]   cc;
    logic              start;
    logic [PID_W-1:0]  pid;
  } pkt_hdr_t;

  function automatic logic [7:0] pkt_byte(
    input logic [7:0]        idx,
    input pkt_hdr_t          hdr,
    input logic [BASE_W-1:0] base,
    input logic [EXT_W-1:0]  ext
  );
    logic [7:0] b;
    b = FILL_BYTE;
    case (hdr.kind)
      KIND_PAT: begin
        if (idx == 8'd3) b = {4'h1, hdr.cc};
        else if (idx < 8'd32) b = PAT_TPL[idx[4:0]];
      end
      KIND_PMT: begin
        if (idx == 8'd3) b = {4'h1, hdr.cc};
        else if (idx < 8'd32) b = PMT_TPL[idx[4:0]];
      end
      KIND_PCR: begin
        case (idx)
          8'd0:    b = SYNC_BYTE;
          8'd1:    b = {3'b010, hdr.pid[12:8]};
          8'd2:    b = hdr.pid[7:0];
          8'd3:    b = {4'h2, hdr.cc};
          8'd4:    b = 8'd183;
          8'd5:    b = 8'h10;
          8'd6:    b = base[32:25];
          8'd7:    b = base[24:17];
          8'd8:    b = base[16:9];
          8'd9:    b = base[8:1];
          8'd10:   b = {base[0], 6'b111111, ext[8]};
          8'd11:   b = ext[7:0];
          default: b = FILL_BYTE;
        endcase
      end
      default: begin
        case (idx)
          8'd0:    b = SYNC_BYTE;
          8'd1:    b = {1'b0, hdr.start, 1'b0, hdr.pid[12:8]};
          8'd2:    b = hdr.pid[7:0];
          8'd3:    b = {4'h1, hdr.cc};
          default: begin
            if (hdr.start && idx < 8'd58) b = START_TPL[idx[5:0]];
          end
        endcase
      end
    endcase
    return b;
  endfunction

  function automatic logic [31:0] pkt_word(
    input logic [IDX_W-1:0]  widx,
    input pkt_hdr_t          hdr,
    input logic [BASE_W-1:0] base,
    input logic [EXT_W-1:0]  ext
  );
    logic [31:0] w;
    w[31:24] = pkt_byte({widx, 2'd0}, hdr, base, ext);
    w[23:16] = pkt_byte({widx, 2'd1}, hdr, base, ext);
    w[15:8]  = pkt_byte({widx, 2'd2}, hdr, base, ext);
    w[7:0]   = pkt_byte({widx, 2'd3}, hdr, base, ext);
    return w;
  endfunction

  function automatic logic [PHASE_W-1:0] phase_advance(
    input logic [PHASE_W-1:0] phase,
    input logic [PHASE_W-1:0] period
  );
    logic [PHASE_W:0] limit;
    logic [PHASE_W:0] nxt;
    limit = (period == '0) ? {1'b1, {PHASE_W{1'b0}}} : {1'b0, period};
    nxt   = {1'b0, phase} + {{PHASE_W{1'b0}}, 1'b1};
    return (nxt >= limit) ? '0 : nxt[PHASE_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/tstg_div300.sv -----
// pipelined divider of the 27 MHz count by 300 for the pcr base and extension
`default_nettype none
module tstg_div300 (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [tstg_pkg::TIME_W-1:0]   dividend_i,
  output logic                               busy_o,
  output logic      [tstg_pkg::BASE_W-1:0]   quot_o,
  output logic      [tstg_pkg::EXT_W-1:0]    rem_o
);
  import tstg_pkg::*;

  // 2^21 = 300 * 6990 + 152, so time = 300 * 6990 * hi + (152 * hi + lo)
  localparam int unsigned HALF_W      = 21;
  localparam int unsigned SUM_W       = 29;
  localparam int unsigned PROD_W      = 59;
  localparam int unsigned QUOT_W      = 34;
  localparam int unsigned RECIP_SHIFT = 38;
  localparam logic [29:0] RECIP       = 30'd916259690;
  localparam logic [12:0] HI_QUOT     = 13'd6990;
  localparam logic [7:0]  HI_REM      = 8'd152;

  logic [HALF_W-1:0] hi_d, lo, hi_q;
  logic [SUM_W-1:0]  sum_d, sum_q;
  logic [PROD_W-1:0] prod;
  logic [HALF_W-1:0] q_lo_d, q_lo_q;
  logic              st1_q, st2_q;
  logic [BASE_W-1:0] quot_q, quot_d;
  logic [EXT_W-1:0]  rem_q, rem_d;

  assign hi_d   = dividend_i[TIME_W-1:HALF_W];
  assign lo     = dividend_i[HALF_W-1:0];
  assign sum_d  = SUM_W'(hi_d) * SUM_W'(HI_REM) + SUM_W'(lo);
  // reciprocal of 300 exact for a 29-bit sum
  assign prod   = PROD_W'(sum_q) * PROD_W'(RECIP);
  assign q_lo_d = prod[PROD_W-1:RECIP_SHIFT];
  assign quot_d = BASE_W'(QUOT_W'(hi_q) * QUOT_W'(HI_QUOT) + QUOT_W'(q_lo_q));
  assign rem_d  = EXT_W'(sum_q - SUM_W'(q_lo_q) * SUM_W'(PCR_DIV));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st1_q <= 1'b0;
      st2_q <= 1'b0;
    end else begin
      st1_q <= start_i;
      st2_q <= st1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      hi_q  <= hi_d;
      sum_q <= sum_d;
    end
    if (st1_q) q_lo_q <= q_lo_d;
    if (st2_q) begin
      quot_q <= quot_d;
      rem_q  <= rem_d;
    end
  end

  assign busy_o = st1_q || st2_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

// ----- rtl/ts_packet_test_generator_unit.sv -----
// top level of the transport packet test generator
//
// one input beat on s_axis requests one 188-byte transport packet; tdata carries the
// current 27 MHz tick count. the packet leaves on m_axis as 47 beats of four bytes,
// earliest byte in the top bits, with word index, packet kind on tuser and tlast on
// the final beat. the packet kind (pat, pmt, pcr-only, video) and continuity counter
// are fixed when the request is taken. a request sits in a one-deep slot while a
// pipelined divider forms time/300 and time%300 through its input, quotient and result
// registers, then moves to the word generator once the divider is idle and the previous
// packet has handed over its last beat.
// on an idle block a request passes the divider, generator and output register in turn;
// with a waiting receiver the block streams one beat per cycle, so requests
// are taken back to back, one per packet, paced by the 47-beat packet length.
// a stalled receiver holds the output register and the generator; the request slot
// stays full and s_axis_tready stays low until it drains.
// reset clears all phases and counters and loads the default register values.
// registers sit on the apb port at byte addresses 0, 4, 8, 12, 16; pready is always high.
`default_nettype none
module ts_packet_test_generator_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // time_27mhz[41:0]
  input  wire logic [47:0] s_axis_tdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // packet_word[31:0], word_index[37:32]
  output logic      [39:0] m_axis_tdata,
  // packet_kind[1:0]
  output logic      [1:0]  m_axis_tuser,
  output logic             m_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import tstg_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PKT_WORDS - 1);

  // configuration
  logic [15:0]      table_period_q, pcr_period_q, video_start_q;
  logic [PID_W-1:0] vid_pid_q, pcr_pid_q;
  logic             cfg_wr;
  logic [2:0]       cfg_idx;

  // stream state
  logic [PHASE_W-1:0] table_phase_q, pcr_phase_q;
  logic [CC_W-1:0]    pat_cc_q, pmt_cc_q, pcr_cc_q, vid_cc_q;

  // request slot
  logic     req_valid_q;
  pkt_hdr_t req_q, req_d;
  logic     in_acc;

  // divider
  logic              div_busy;
  logic [BASE_W-1:0] div_quot;
  logic [EXT_W-1:0]  div_rem;

  // generator
  logic              pkt_active_q;
  logic [IDX_W-1:0]  widx_q;
  pkt_hdr_t          pkt_q;
  logic [BASE_W-1:0] base_q;
  logic [EXT_W-1:0]  ext_q;
  logic              out_adv, pkt_emit, pkt_free, pkt_load;

  // output register
  logic              out_valid_q;
  logic [31:0]       out_word_q;
  logic [IDX_W-1:0]  out_idx_q;
  logic [KIND_W-1:0] out_kind_q;
  logic              out_last_q;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_comb begin
    case (cfg_idx)
      REG_TABLE_PERIOD: prdata = {16'd0, table_period_q};
      REG_PCR_PERIOD:   prdata = {16'd0, pcr_period_q};
      REG_VIDEO_START:  prdata = {16'd0, video_start_q};
      REG_VID_PID:      prdata = {19'd0, vid_pid_q};
      REG_PCR_PID:      prdata = {19'd0, pcr_pid_q};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_period_q <= TABLE_PERIOD_RST;
      pcr_period_q   <= PCR_PERIOD_RST;
      video_start_q  <= VIDEO_START_RST;
      vid_pid_q      <= VID_PID_RST;
      pcr_pid_q      <= PCR_PID_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_TABLE_PERIOD: table_period_q <= pwdata[15:0];
        REG_PCR_PERIOD:   pcr_period_q   <= pwdata[15:0];
        REG_VIDEO_START:  video_start_q  <= pwdata[15:0];
        REG_VID_PID:      vid_pid_q      <= pwdata[PID_W-1:0];
        REG_PCR_PID:      pcr_pid_q      <= pwdata[PID_W-1:0];
        default: ;
      endcase
    end
  end

  // packet kind and counter chosen on request
  assign s_axis_tready = !req_valid_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    req_d.start = 1'b0;
    req_d.pid   = '0;
    if (table_phase_q == 16'd0) begin
      req_d.kind = KIND_PAT;
      req_d.cc   = pat_cc_q;
    end else if (table_phase_q == 16'd1) begin
      req_d.kind = KIND_PMT;
      req_d.cc   = pmt_cc_q;
    end else if (pcr_phase_q == 16'd0) begin
      req_d.kind = KIND_PCR;
      req_d.cc   = pcr_cc_q;
      req_d.pid  = pcr_pid_q;
    end else begin
      req_d.kind  = KIND_VIDEO;
      req_d.cc    = vid_cc_q;
      req_d.pid   = vid_pid_q;
      req_d.start = (table_phase_q == video_start_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_phase_q <= '0;
      pcr_phase_q   <= '0;
      pat_cc_q      <= '0;
      pmt_cc_q      <= '0;
      pcr_cc_q      <= '0;
      vid_cc_q      <= '0;
    end else if (in_acc) begin
      table_phase_q <= phase_advance(table_phase_q, table_period_q);
      pcr_phase_q   <= phase_advance(pcr_phase_q, pcr_period_q);
      case (req_d.kind)
        KIND_PAT: pat_cc_q <= pat_cc_q + CC_W'(1);
        KIND_PMT: pmt_cc_q <= pmt_cc_q + CC_W'(1);
        KIND_PCR: pcr_cc_q <= pcr_cc_q + CC_W'(1);
        default:  vid_cc_q <= vid_cc_q + CC_W'(1);
      endcase
    end
  end

  tstg_div300 u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_acc),
    .dividend_i (s_axis_tdata[TIME_W-1:0]),
    .busy_o     (div_busy),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign out_adv  = !out_valid_q || m_axis_tready;
  assign pkt_emit = pkt_active_q && out_adv;
  assign pkt_free = !pkt_active_q || (pkt_emit && widx_q == LAST_IDX);
  assign pkt_load = req_valid_q && !div_busy && pkt_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_acc) begin
      req_valid_q <= 1'b1;
    end else if (pkt_load) begin
      req_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) req_q <= req_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_active_q <= 1'b0;
      widx_q       <= '0;
    end else if (pkt_load) begin
      pkt_active_q <= 1'b1;
      widx_q       <= '0;
    end else if (pkt_emit) begin
      if (widx_q == LAST_IDX) pkt_active_q <= 1'b0;
      widx_q <= widx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pkt_load) begin
      pkt_q  <= req_q;
      base_q <= div_quot;
      ext_q  <= div_rem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= pkt_active_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pkt_emit) begin
      out_word_q <= pkt_word(widx_q, pkt_q, base_q, ext_q);
      out_idx_q  <= widx_q;
      out_kind_q <= pkt_q.kind;
      out_last_q <= (widx_q == LAST_IDX);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'd0, out_idx_q, out_word_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

  logic unused_tdata;
  assign unused_tdata = ^s_axis_tdata[47:TIME_W] ^ ^paddr[1:0] ^ ^pwdata[31:16];

endmodule
`default_nettype wire
